[hdl/integer_bit_count_unit_macros.svh]
// integer_bit_count_unit_macros.svh: assertion macros for the bit count unit.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef INTEGER_BIT_COUNT_UNIT_MACROS_SVH
`define INTEGER_BIT_COUNT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent and consequent on the same edge
`define IBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_bit_count_unit check failed");
// consequent on the edge after the antecedent completes
`define IBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_bit_count_unit check failed");
`else
`define IBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/ibc_pkg.sv]
// ibc_pkg: constants, opcode and type codes, stage-advance struct and
// bit helper functions for the integer bit count unit. No dependencies.
package ibc_pkg;

    localparam int LANES   = 4;
    localparam int NUM_OUT = 4;
    localparam int WORD_W  = 32;
    localparam int RES_W   = 33;
    localparam int CNT_W   = 6;

    localparam logic [2:0] OP_POP = 3'd0;
    localparam logic [2:0] OP_LZC = 3'd1;
    localparam logic [2:0] OP_TZC = 3'd2;
    localparam logic [2:0] OP_REV = 3'd3;
    localparam logic [2:0] OP_FTB = 3'd4;
    localparam logic [2:0] OP_FLB = 3'd5;

    localparam logic [1:0] TY_U32 = 2'd0;
    localparam logic [1:0] TY_I32 = 2'd1;
    localparam logic [1:0] TY_ABS = 2'd2;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    function automatic logic [WORD_W-1:0] bit_rev(input logic [WORD_W-1:0] w_in);
        logic [WORD_W-1:0] w;
        begin
            w = w_in;
            w = ((w & 32'h5555_5555) << 1) | ((w >> 1) & 32'h5555_5555);
            w = ((w & 32'h3333_3333) << 2) | ((w >> 2) & 32'h3333_3333);
            w = ((w & 32'h0f0f_0f0f) << 4) | ((w >> 4) & 32'h0f0f_0f0f);
            w = ((w & 32'h00ff_00ff) << 8) | ((w >> 8) & 32'h00ff_00ff);
            bit_rev = (w << 16) | (w >> 16);
        end
    endfunction

    function automatic logic [3:0] byte_pop(input logic [7:0] b);
        logic [3:0] n;
        begin
            n = 4'd0;
            for (int i = 0; i < 8; i++)
            begin
                n = n + {3'd0, b[i]};
            end
            byte_pop = n;
        end
    endfunction

    // trailing zeros of a nonzero byte
    function automatic logic [2:0] byte_tz(input logic [7:0] b);
        logic [2:0] n;
        begin
            n = 3'd0;
            for (int i = 7; i >= 0; i--)
            begin
                if (b[i])
                begin
                    n = 3'(i);
                end
            end
            byte_tz = n;
        end
    endfunction

endpackage

[hdl/integer_bit_count_unit.sv]
// integer_bit_count_unit: lane-wise popcount, leading/trailing zeros, bit
// reverse, first trailing/leading bit. Depends on ibc_pkg, ibc_ctrl, ibc_lane.
//
// Takes one item per clock while result_ready stays high; every lane has
// three register stages (operand select and reverse, per-byte counts, final
// combine), and the third stage is the output register, so ready stays high
// while a result waits as long as an earlier stage is free. Lanes at or
// beyond lane_count and opcodes 6 and 7 return zero.
`include "integer_bit_count_unit_macros.svh"
module integer_bit_count_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    output logic                              ready,
    input  logic [2:0]                        opcode,
    input  logic [1:0]                        element_type,
    input  logic [2:0]                        lane_count,
    input  logic [ibc_pkg::WORD_W-1:0]        value_0,
    input  logic [ibc_pkg::WORD_W-1:0]        value_1,
    input  logic [ibc_pkg::WORD_W-1:0]        value_2,
    input  logic [ibc_pkg::WORD_W-1:0]        value_3,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [ibc_pkg::RES_W-1:0]  result_0,
    output logic signed [ibc_pkg::RES_W-1:0]  result_1,
    output logic signed [ibc_pkg::RES_W-1:0]  result_2,
    output logic signed [ibc_pkg::RES_W-1:0]  result_3
);
    import ibc_pkg::*;

    adv_t                     adv;
    logic [WORD_W-1:0]        lane_val [NUM_OUT];
    logic signed [RES_W-1:0]  lane_res [NUM_OUT];
    logic [NUM_OUT-1:0]       lane_en;

    assign lane_val[0] = value_0;
    assign lane_val[1] = value_1;
    assign lane_val[2] = value_2;
    assign lane_val[3] = value_3;

    assign result_0 = lane_res[0];
    assign result_1 = lane_res[1];
    assign result_2 = lane_res[2];
    assign result_3 = lane_res[3];

    ibc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .adv          (adv)
    );

    for (genvar i = 0; i < NUM_OUT; i++)
    begin : g_lane
        assign lane_en[i] = (lane_count > 3'(i)) && (i < LANES);

        ibc_lane u_lane (
            .clk          (clk),
            .adv          (adv),
            .opcode       (opcode),
            .element_type (element_type),
            .lane_en      (lane_en[i]),
            .value        (lane_val[i]),
            .result       (lane_res[i])
        );
    end

    // output ready lets every stage move
    `IBC_ASSERT_IMP(a_ready_chain, clk, rst_n, result_ready, ready)
    // unknown opcode, no stall: all-zero result once it reaches the output
    `IBC_ASSERT_NXT(a_bad_op_zero, clk, rst_n, valid && ready && opcode[2] && opcode[1] ##1 result_ready ##1 result_ready, result_valid && result_0 == '0 && result_1 == '0 && result_2 == '0 && result_3 == '0)
    // single lane, no stall: upper lanes are zero
    `IBC_ASSERT_NXT(a_one_lane_zero, clk, rst_n, valid && ready && lane_count == 3'd1 ##1 result_ready ##1 result_ready, result_valid && result_1 == '0 && result_2 == '0 && result_3 == '0)

endmodule

[hdl/ibc_ctrl.sv]
// ibc_ctrl: valid bits and stage advance for the three-stage pipeline.
// Depends on ibc_pkg.
module ibc_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid,
    output logic         ready,
    output logic         result_valid,
    input  logic         result_ready,
    output ibc_pkg::adv_t adv
);
    import ibc_pkg::*;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv.s3 = !v3_reg || result_ready;
        adv.s2 = !v2_reg || adv.s3;
        adv.s1 = !v1_reg || adv.s2;
    end

    assign ready        = adv.s1;
    assign result_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
            begin
                v1_reg <= valid;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.s3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

endmodule

[hdl/ibc_lane.sv]
// ibc_lane: one lane's datapath: operand select and reverse, byte counts,
// then final count, raw result and per-type reading. Depends on ibc_pkg.
module ibc_lane (
    input  logic                               clk,
    input  ibc_pkg::adv_t                      adv,
    input  logic [2:0]                         opcode,
    input  logic [1:0]                         element_type,
    input  logic                               lane_en,
    input  logic [ibc_pkg::WORD_W-1:0]         value,
    output logic signed [ibc_pkg::RES_W-1:0]   result
);
    import ibc_pkg::*;

    // stage 1
    logic [2:0]        op1_reg;
    logic [1:0]        ty1_reg;
    logic              live1_reg;
    logic [WORD_W-1:0] x1_reg;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] x1_next;

    // stage 2
    logic [2:0]        op2_reg;
    logic [1:0]        ty2_reg;
    logic              live2_reg;
    logic [WORD_W-1:0] x2_reg;
    logic [3:0]        pop2_reg [4];
    logic [2:0]        tz2_reg  [4];
    logic [3:0]        nz2_reg;

    // stage 3
    logic [CNT_W-1:0]  pop;
    logic [CNT_W-1:0]  tz;
    logic              zero;
    logic [WORD_W-1:0] raw;
    logic [RES_W-1:0]  res_next;
    logic [RES_W-1:0]  res_reg;

    // leading-bit ops work as trailing-bit ops on the reversed word
    always_comb
    begin
        y = value;
        if (opcode == OP_FLB && (element_type == TY_I32 || element_type == TY_ABS)
            && value[WORD_W-1])
        begin
            y = ~value;
        end
        case (opcode) inside
            OP_LZC, OP_REV, OP_FLB: x1_next = bit_rev(y);
            default:                x1_next = value;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            op1_reg   <= opcode;
            ty1_reg   <= element_type;
            live1_reg <= lane_en && (opcode <= OP_FLB);
            x1_reg    <= x1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            op2_reg   <= op1_reg;
            ty2_reg   <= ty1_reg;
            live2_reg <= live1_reg;
            x2_reg    <= x1_reg;
            for (int b = 0; b < 4; b++)
            begin
                pop2_reg[b] <= byte_pop(x1_reg[8*b +: 8]);
                tz2_reg[b]  <= byte_tz(x1_reg[8*b +: 8]);
                nz2_reg[b]  <= |x1_reg[8*b +: 8];
            end
        end
    end

    always_comb
    begin
        pop = CNT_W'(pop2_reg[0]) + CNT_W'(pop2_reg[1])
            + CNT_W'(pop2_reg[2]) + CNT_W'(pop2_reg[3]);
        zero = ~|nz2_reg;
        if (nz2_reg[0])
            tz = {3'd0, tz2_reg[0]};
        else if (nz2_reg[1])
            tz = {3'd1, tz2_reg[1]};
        else if (nz2_reg[2])
            tz = {3'd2, tz2_reg[2]};
        else if (nz2_reg[3])
            tz = {3'd3, tz2_reg[3]};
        else
            tz = CNT_W'(WORD_W);

        case (op2_reg) inside
            OP_POP:         raw = WORD_W'(pop);
            OP_LZC, OP_TZC: raw = WORD_W'(tz);
            OP_REV:         raw = x2_reg;
            OP_FTB:         raw = zero ? ALL_ONES : WORD_W'(tz);
            OP_FLB:         raw = zero ? ALL_ONES : WORD_W'(5'd31 - tz[4:0]);
            default:        raw = '0;
        endcase

        if (!live2_reg)
            res_next = '0;
        else if (ty2_reg == TY_I32)
            res_next = {raw[WORD_W-1], raw};
        else if (ty2_reg == TY_ABS && raw == ALL_ONES)
            res_next = '1;
        else
            res_next = {1'b0, raw};
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign result = signed'(res_reg);

endmodule

[sim/integer_bit_count_unit_test.sv]
`timescale 1ns / 1ps
// integer_bit_count_unit_test: self-checking bench for the lane-wise integer bit op unit.
// Directed corner items, then random items under four pacing modes, checked by a predictor.
// Depends on ibc_pkg and integer_bit_count_unit.
module integer_bit_count_unit_test;
    import ibc_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;
    localparam logic [1:0] TY_RSVD   = 2'd3;

    localparam int ITEMS_PER_MODE = 500;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int SEND_IDLE [4]  = '{0, 67, 0, 25};
    localparam int RECV_STALL [4] = '{0, 0, 67, 25};

    typedef struct packed {
        logic [2:0]                     opcode;
        logic [1:0]                     element_type;
        logic [2:0]                     lane_count;
        logic [NUM_OUT-1:0][WORD_W-1:0] words;
    } bitop_item_t;

    typedef logic [NUM_OUT-1:0][RES_W-1:0] lane_results_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     valid = 1'b0;
    logic                     ready;
    logic [2:0]               opcode = '0;
    logic [1:0]               element_type = '0;
    logic [2:0]               lane_count = '0;
    logic [WORD_W-1:0]        value_0 = '0;
    logic [WORD_W-1:0]        value_1 = '0;
    logic [WORD_W-1:0]        value_2 = '0;
    logic [WORD_W-1:0]        value_3 = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic signed [RES_W-1:0]  result_0;
    logic signed [RES_W-1:0]  result_1;
    logic signed [RES_W-1:0]  result_2;
    logic signed [RES_W-1:0]  result_3;

    bitop_item_t   pending_items [$];
    lane_results_t expected_results [$];
    bitop_item_t   next_item;
    lane_results_t want;
    lane_results_t got;
    logic          in_taken = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int unsigned   items_sent = 0;
    int unsigned   results_checked = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;

    integer_bit_count_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .opcode       (opcode),
        .element_type (element_type),
        .lane_count   (lane_count),
        .value_0      (value_0),
        .value_1      (value_1),
        .value_2      (value_2),
        .value_3      (value_3),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_0     (result_0),
        .result_1     (result_1),
        .result_2     (result_2),
        .result_3     (result_3)
    );

    function automatic int count_ones(input logic [WORD_W-1:0] w);
        int n;
        n = 0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n += w[i];
        end
        return n;
    endfunction

    function automatic int lead_zero_count(input logic [WORD_W-1:0] w);
        int n;
        n = 0;
        while (n < WORD_W && !w[WORD_W-1-n])
        begin
            n++;
        end
        return n;
    endfunction

    function automatic int trail_zero_count(input logic [WORD_W-1:0] w);
        int n;
        n = 0;
        while (n < WORD_W && !w[n])
        begin
            n++;
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] mirror_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++)
        begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [RES_W-1:0] bit_op_lane(input logic [2:0] op,
                                                     input logic [1:0] ty,
                                                     input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] probe;
        logic              sign_aware;
        sign_aware = (ty == TY_I32) || (ty == TY_ABS);
        case (op)
            OP_POP: raw = WORD_W'(count_ones(w));
            OP_LZC: raw = WORD_W'(lead_zero_count(w));
            OP_TZC: raw = WORD_W'(trail_zero_count(w));
            OP_REV: raw = mirror_word(w);
            OP_FTB: raw = (w == '0) ? ALL_ONES : WORD_W'(trail_zero_count(w));
            OP_FLB:
            begin
                probe = (sign_aware && w[WORD_W-1]) ? ~w : w;
                raw = (probe == '0) ? ALL_ONES : WORD_W'(31 - lead_zero_count(probe));
            end
            default: return '0;
        endcase
        if (ty == TY_I32)
        begin
            return {raw[WORD_W-1], raw};
        end
        if (ty == TY_ABS && raw == ALL_ONES)
        begin
            return '1;
        end
        return {1'b0, raw};
    endfunction

    function automatic lane_results_t predict_item(input bitop_item_t it);
        lane_results_t r;
        int            active;
        active = (it.lane_count > NUM_OUT) ? NUM_OUT : it.lane_count;
        if (active > LANES)
        begin
            active = LANES;
        end
        for (int i = 0; i < NUM_OUT; i++)
        begin
            r[i] = (i < active) ? bit_op_lane(it.opcode, it.element_type, it.words[i]) : '0;
        end
        return r;
    endfunction

    function automatic bitop_item_t make_item(input logic [2:0] op, input logic [1:0] ty,
                                              input logic [2:0] cnt,
                                              input logic [WORD_W-1:0] w0,
                                              input logic [WORD_W-1:0] w1,
                                              input logic [WORD_W-1:0] w2,
                                              input logic [WORD_W-1:0] w3);
        bitop_item_t it;
        it.opcode       = op;
        it.element_type = ty;
        it.lane_count   = cnt;
        it.words        = {w3, w2, w1, w0};
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int sh;
        sh = $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1) << sh;
            3: return ~(WORD_W'(1) << sh);
            4: return $urandom >> sh;
            5: return 32'h8000_0000 | ($urandom >> sh);
            default: return $urandom;
        endcase
    endfunction

    function automatic bitop_item_t random_item();
        bitop_item_t it;
        it.opcode = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 5))
                                                 : 3'($urandom_range(6, 7));
        it.element_type = ($urandom_range(0, 9) == 0) ? TY_RSVD : 2'($urandom_range(0, 2));
        it.lane_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
        for (int i = 0; i < NUM_OUT; i++)
        begin
            it.words[i] = random_word();
        end
        return it;
    endfunction

    task automatic load_directed();
        logic [2:0] plain_ops [6];
        logic [1:0] all_types [4];
        logic [2:0] odd_counts [7];
        plain_ops  = '{OP_POP, OP_LZC, OP_TZC, OP_REV, OP_RSVD_A, OP_RSVD_B};
        all_types  = '{TY_U32, TY_I32, TY_ABS, TY_RSVD};
        odd_counts = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};
        foreach (plain_ops[i])
        begin
            pending_items.push_back(make_item(plain_ops[i], all_types[i % 4], 3'd4,
                32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        end
        // first-bit searches: not found, negative words, top bit only
        foreach (all_types[i])
        begin
            pending_items.push_back(make_item(OP_FTB, all_types[i], 3'd4,
                32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
            pending_items.push_back(make_item(OP_FLB, all_types[i], 3'd4,
                32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        end
        foreach (odd_counts[i])
        begin
            pending_items.push_back(make_item(OP_REV, TY_I32, odd_counts[i],
                32'h1234_5678, 32'hA5A5_A5A5, 32'hFFFF_0000, 32'h0000_FFFF));
        end
    endtask

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid        <= 1'b0;
            result_ready <= 1'b0;
        end
        else
        begin
            if (!valid || in_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    valid        <= 1'b1;
                    opcode       <= next_item.opcode;
                    element_type <= next_item.element_type;
                    lane_count   <= next_item.lane_count;
                    value_0      <= next_item.words[0];
                    value_1      <= next_item.words[1];
                    value_2      <= next_item.words[2];
                    value_3      <= next_item.words[3];
                end
                else
                begin
                    valid <= 1'b0;
                end
            end
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= valid && ready;
            if (valid && ready)
            begin
                expected_results.push_back(predict_item(make_item(opcode, element_type,
                    lane_count, value_0, value_1, value_2, value_3)));
                items_sent++;
            end
            if (result_valid && result_ready)
            begin
                got = {result_3, result_2, result_1, result_0};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result item %h", $realtime, got);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    for (int i = 0; i < NUM_OUT; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= MAX_REPORTS)
                            begin
                                $display("%0t: result_%0d expected %h actual %h",
                                         $realtime, i, want[i], got[i]);
                            end
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(valid && ready) && !(result_valid && result_ready))
        begin
            quiet_cycles++;
        end
        else
        begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = SEND_IDLE[m];
            recv_stall_pct = RECV_STALL[m];
            if (m == 0)
            begin
                load_directed();
            end
            for (int k = 0; k < ITEMS_PER_MODE; k++)
            begin
                pending_items.push_back(random_item());
            end
            while (pending_items.size() > 0 || valid || expected_results.size() > 0)
            begin
                @(posedge clk);
            end
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d items (corner words, all opcodes and types, lane counts 0-7)",
                 items_sent);
        $display("across four sender/receiver pacing modes; %0d results checked, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
